[rtl/core/maze_backtracker_step_core_macros.svh]
// Assertion helpers for the maze step core.
`ifndef MAZE_BACKTRACKER_STEP_CORE_MACROS_SVH
`define MAZE_BACKTRACKER_STEP_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define MBS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/maze_bt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package maze_bt_pkg;

    localparam int CFG_W  = 5;
    localparam int IDX_W  = 1;
    localparam int OP_W   = 2;
    localparam int KIND_W = 3;
    localparam int DIR_W  = 2;
    localparam int WALL_W = 4;
    localparam int POS_W  = 4;
    localparam int RND_W  = 16;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;
    localparam int DEPTH_W = 9;

    typedef logic [IDX_W-1:0]  cfg_idx_t;
    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [DIR_W-1:0]  dir_t;
    typedef logic [WALL_W-1:0] wall_t;

    localparam cfg_idx_t REG_COLS = 1'd0;
    localparam cfg_idx_t REG_ROWS = 1'd1;

    localparam opcode_t OP_STEP    = 2'd0;
    localparam opcode_t OP_RESTART = 2'd1;
    localparam opcode_t OP_READ    = 2'd2;

    localparam kind_t EV_CARVED    = 3'd0;
    localparam kind_t EV_BACKTRACK = 3'd1;
    localparam kind_t EV_COMPLETE  = 3'd2;
    localparam kind_t EV_RESTARTED = 3'd3;
    localparam kind_t EV_READOUT   = 3'd4;

    localparam dir_t DIR_LEFT  = 2'd0;
    localparam dir_t DIR_RIGHT = 2'd1;
    localparam dir_t DIR_UP    = 2'd2;
    localparam dir_t DIR_DOWN  = 2'd3;

    localparam wall_t WALLS_ALL = 4'hF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROW_HERE,
        ST_ROW_UP,
        ST_ROW_DOWN,
        ST_WALL_FAR,
        ST_POP,
        ST_EMIT
    } state_t;

    // wall bits: bit0 up, bit1 down, bit2 right, bit3 left
    function automatic wall_t own_wall(input dir_t d);
        wall_t m;
        case (d)
            DIR_LEFT:  m = 4'b1000;
            DIR_RIGHT: m = 4'b0100;
            DIR_UP:    m = 4'b0001;
            DIR_DOWN:  m = 4'b0010;
            default:   m = 4'b0000;
        endcase
        return m;
    endfunction

    function automatic wall_t far_wall(input dir_t d);
        wall_t m;
        case (d)
            DIR_LEFT:  m = 4'b0100;
            DIR_RIGHT: m = 4'b1000;
            DIR_UP:    m = 4'b0010;
            DIR_DOWN:  m = 4'b0001;
            default:   m = 4'b0000;
        endcase
        return m;
    endfunction

    // 4 == 1 mod 3, so base-4 digits sum to the same residue
    function automatic logic [1:0] mod3_u16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            r = 2'(t - 3'd6);
        end else if (t >= 3'd3) begin
            r = 2'(t - 3'd3);
        end else begin
            r = 2'(t);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/maze_backtracker_step_core.sv]
// Step: the visited rows are read in turn (own row, above, below) in ST_ROW_HERE,
//   ST_ROW_UP, ST_ROW_DOWN, then ST_WALL_FAR (carve) or ST_POP (backtrack), ST_EMIT;
//   an empty-stack backtrack skips ST_POP. Read: ST_READ, ST_EMIT. Completed-maze step:
//   ST_EMIT. Restart: a clearing pass over walls and visited bits, then ST_EMIT.
// Throughput: one item at a time; the next transfer follows the load of its result.
// Reset (aresetn low, synchronous): same clearing pass, registers 15, cell 0,0, stack empty.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_backtracker_step_core_macros.svh"

module maze_backtracker_step_core #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire maze_bt_pkg::cfg_idx_t         cfg_index,
    input  wire logic [maze_bt_pkg::CFG_W-1:0] cfg_data,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // random_value[15:0], read_col[19:16], read_row[23:20]
    input  wire logic [maze_bt_pkg::IN_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire maze_bt_pkg::opcode_t          s_tuser,

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // from_col[3:0], from_row[7:4], to_col[11:8], to_row[15:12], carved_dir[17:16],
    // wall_bits[21:18], stack_depth[30:22], maze_done[31]
    output logic [maze_bt_pkg::OUT_W-1:0]      m_tdata,
    // event_kind[2:0]
    output maze_bt_pkg::kind_t                 m_tuser
);

    import maze_bt_pkg::*;

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int AW    = CW + RW;
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int SIW   = $clog2(CELLS);
    localparam int SPW   = $clog2(CELLS + 1);
    localparam int XW    = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int DW    = (SPW > 2 * XW) ? SPW : 2 * XW;

    // memories
    logic [GRID_COLS-1:0] vis_mem [2**RW];
    wall_t                wall_mem [2**AW];
    logic [AW-1:0]        stk_mem [CELLS];

    logic                 vis_we;
    logic [RW-1:0]        vis_waddr, vis_raddr;
    logic [GRID_COLS-1:0] vis_wdata, vis_rd_reg;
    logic                 wall_we;
    logic [AW-1:0]        wall_waddr, wall_raddr;
    wall_t                wall_wdata, wall_rd_reg;
    logic                 stk_we;
    logic [SIW-1:0]       stk_waddr, stk_raddr;
    logic [AW-1:0]        stk_wdata, stk_rd_reg;

    // control and walk state
    state_t         state_reg, state_next;
    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [SPW-1:0] vis_cnt_reg, vis_cnt_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           clr_emit_reg, clr_emit_next;
    logic [1:0]     nb_vis_reg, nb_vis_next;
    logic           up_vis_reg, up_vis_next;

    // per-item payload
    logic [1:0]     rnd_mod3_reg, rnd_mod3_next;
    logic [1:0]     rnd_lo_reg, rnd_lo_next;
    logic           in_grid_reg, in_grid_next;
    kind_t          pend_kind_reg, pend_kind_next;
    logic [POS_W-1:0] pend_fcol_reg, pend_fcol_next;
    logic [POS_W-1:0] pend_frow_reg, pend_frow_next;
    dir_t           pend_dir_reg, pend_dir_next;
    wall_t          pend_walls_reg, pend_walls_next;

    // output register
    logic           m_valid_reg, m_valid_next;
    logic           out_load;
    kind_t          out_kind_reg;
    logic [POS_W-1:0] out_fcol_reg, out_frow_reg, out_tcol_reg, out_trow_reg;
    dir_t           out_dir_reg;
    wall_t          out_walls_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic           out_done_reg;

    // derived
    logic [XW-1:0]  eff_cols, eff_rows, ccx, crx;
    logic [2*XW-1:0] area;
    logic           done_now;
    logic [CW-1:0]  col_m1, col_p1;
    logic [RW-1:0]  row_m1, row_p1;
    logic [SPW-1:0] sp_m1;
    logic [3:0]     cand;
    logic [2:0]     cand_n;
    logic [1:0]     pick_k;
    dir_t           pick_dir;
    logic [POS_W-1:0] rd_col, rd_row;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign rd_col    = s_tdata[RND_W +: POS_W];
    assign rd_row    = s_tdata[RND_W + POS_W +: POS_W];

    always_comb begin
        if (cols_reg == '0) begin
            eff_cols = XW'(1);
        end else if (XW'(cols_reg) > XW'(GRID_COLS)) begin
            eff_cols = XW'(GRID_COLS);
        end else begin
            eff_cols = XW'(cols_reg);
        end
        if (rows_reg == '0) begin
            eff_rows = XW'(1);
        end else if (XW'(rows_reg) > XW'(GRID_ROWS)) begin
            eff_rows = XW'(GRID_ROWS);
        end else begin
            eff_rows = XW'(rows_reg);
        end
    end

    assign area     = eff_cols * eff_rows;
    assign done_now = (DW'(vis_cnt_reg) >= DW'(area));
    assign ccx      = XW'(cur_col_reg);
    assign crx      = XW'(cur_row_reg);
    assign col_m1   = cur_col_reg - CW'(1);
    assign col_p1   = cur_col_reg + CW'(1);
    assign row_m1   = cur_row_reg - RW'(1);
    assign row_p1   = cur_row_reg + RW'(1);
    assign sp_m1    = sp_reg - SPW'(1);

    // unvisited in-use neighbours, order left, right, up, down
    always_comb begin
        cand[0] = (cur_col_reg != '0) && (ccx <= eff_cols) && (crx < eff_rows)
                  && !nb_vis_reg[0];
        cand[1] = ((ccx + XW'(1)) < eff_cols) && (crx < eff_rows) && !nb_vis_reg[1];
        cand[2] = (cur_row_reg != '0) && (crx <= eff_rows) && (ccx < eff_cols)
                  && !up_vis_reg;
        cand[3] = ((crx + XW'(1)) < eff_rows) && (ccx < eff_cols)
                  && !vis_rd_reg[cur_col_reg];
        cand_n  = 3'($countones(cand));
    end

    always_comb begin
        logic [1:0] seen;
        logic       found;
        case (cand_n)
            3'd2:    pick_k = {1'b0, rnd_lo_reg[0]};
            3'd3:    pick_k = rnd_mod3_reg;
            3'd4:    pick_k = rnd_lo_reg;
            default: pick_k = 2'd0;
        endcase
        seen     = 2'd0;
        found    = 1'b0;
        pick_dir = DIR_LEFT;
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (!found && (seen == pick_k)) begin
                    pick_dir = dir_t'(d);
                    found    = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        sp_next         = sp_reg;
        vis_cnt_next    = vis_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_emit_next   = clr_emit_reg;
        nb_vis_next     = nb_vis_reg;
        up_vis_next     = up_vis_reg;
        rnd_mod3_next   = rnd_mod3_reg;
        rnd_lo_next     = rnd_lo_reg;
        in_grid_next    = in_grid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_fcol_next  = pend_fcol_reg;
        pend_frow_next  = pend_frow_reg;
        pend_dir_next   = pend_dir_reg;
        pend_walls_next = pend_walls_reg;
        m_valid_next    = m_valid_reg;

        vis_we     = 1'b0;
        vis_waddr  = cur_row_reg;
        vis_wdata  = vis_rd_reg;
        vis_raddr  = cur_row_reg;
        wall_we    = 1'b0;
        wall_waddr = {cur_row_reg, cur_col_reg};
        wall_wdata = wall_rd_reg;
        wall_raddr = {cur_row_reg, cur_col_reg};
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[SIW-1:0];
        stk_wdata  = {cur_row_reg, cur_col_reg};
        stk_raddr  = sp_m1[SIW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                vis_we     = 1'b1;
                vis_waddr  = clr_cnt_reg[AW-1:CW];
                vis_wdata  = '0;
                wall_we    = 1'b1;
                wall_waddr = clr_cnt_reg;
                wall_wdata = WALLS_ALL;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = clr_emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    pend_fcol_next  = POS_W'(cur_col_reg);
                    pend_frow_next  = POS_W'(cur_row_reg);
                    pend_dir_next   = DIR_LEFT;
                    pend_walls_next = '0;
                    rnd_mod3_next   = mod3_u16(s_tdata[RND_W-1:0]);
                    rnd_lo_next     = s_tdata[1:0];
                    case (s_tuser)
                        OP_RESTART: begin
                            pend_kind_next = EV_RESTARTED;
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            sp_next        = '0;
                            vis_cnt_next   = '0;
                            clr_cnt_next   = '0;
                            clr_emit_next  = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        OP_STEP: begin
                            if (done_now) begin
                                pend_kind_next = EV_COMPLETE;
                                state_next     = ST_EMIT;
                            end else begin
                                state_next     = ST_ROW_HERE;
                            end
                        end
                        default: begin
                            pend_kind_next = EV_READOUT;
                            in_grid_next   = (XW'(rd_col) < XW'(GRID_COLS))
                                             && (XW'(rd_row) < XW'(GRID_ROWS));
                            wall_raddr     = {RW'(rd_row), CW'(rd_col)};
                            state_next     = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                pend_walls_next = in_grid_reg ? wall_rd_reg : WALLS_ALL;
                state_next      = ST_EMIT;
            end
            ST_ROW_HERE: begin
                vis_we = 1'b1;
                vis_wdata[cur_col_reg] = 1'b1;
                if (!vis_rd_reg[cur_col_reg]) begin
                    vis_cnt_next = vis_cnt_reg + SPW'(1);
                end
                nb_vis_next[0] = (cur_col_reg != '0) ? vis_rd_reg[col_m1] : 1'b1;
                nb_vis_next[1] = (cur_col_reg != CW'(GRID_COLS - 1))
                                 ? vis_rd_reg[col_p1] : 1'b1;
                vis_raddr  = (cur_row_reg != '0) ? row_m1 : cur_row_reg;
                state_next = ST_ROW_UP;
            end
            ST_ROW_UP: begin
                up_vis_next = vis_rd_reg[cur_col_reg];
                vis_raddr   = (cur_row_reg != RW'(GRID_ROWS - 1)) ? row_p1 : cur_row_reg;
                state_next  = ST_ROW_DOWN;
            end
            ST_ROW_DOWN: begin
                if (cand_n != 3'd0) begin
                    pend_kind_next = EV_CARVED;
                    pend_dir_next  = pick_dir;
                    wall_we        = 1'b1;
                    wall_wdata     = wall_rd_reg & ~own_wall(pick_dir);
                    if (sp_reg < SPW'(CELLS)) begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + SPW'(1);
                    end
                    case (pick_dir)
                        DIR_LEFT:  cur_col_next = col_m1;
                        DIR_RIGHT: cur_col_next = col_p1;
                        DIR_UP:    cur_row_next = row_m1;
                        default:   cur_row_next = row_p1;
                    endcase
                    wall_raddr = {cur_row_next, cur_col_next};
                    state_next = ST_WALL_FAR;
                end else begin
                    pend_kind_next = EV_BACKTRACK;
                    if (sp_reg != '0) begin
                        sp_next    = sp_m1;
                        state_next = ST_POP;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALL_FAR: begin
                wall_we    = 1'b1;
                wall_wdata = wall_rd_reg & ~far_wall(pend_dir_reg);
                state_next = ST_EMIT;
            end
            ST_POP: begin
                cur_col_next = stk_rd_reg[CW-1:0];
                cur_row_next = stk_rd_reg[AW-1:CW];
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[vis_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wall_we) begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        wall_rd_reg <= wall_mem[wall_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cols_reg     <= CFG_W'(15);
            rows_reg     <= CFG_W'(15);
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            sp_reg       <= '0;
            vis_cnt_reg  <= '0;
            clr_cnt_reg  <= '0;
            clr_emit_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            sp_reg       <= sp_next;
            vis_cnt_reg  <= vis_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_emit_reg <= clr_emit_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COLS: cols_reg <= cfg_data;
                    REG_ROWS: rows_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        nb_vis_reg     <= nb_vis_next;
        up_vis_reg     <= up_vis_next;
        rnd_mod3_reg   <= rnd_mod3_next;
        rnd_lo_reg     <= rnd_lo_next;
        in_grid_reg    <= in_grid_next;
        pend_kind_reg  <= pend_kind_next;
        pend_fcol_reg  <= pend_fcol_next;
        pend_frow_reg  <= pend_frow_next;
        pend_dir_reg   <= pend_dir_next;
        pend_walls_reg <= pend_walls_next;
        if (out_load) begin
            out_kind_reg  <= pend_kind_reg;
            out_fcol_reg  <= pend_fcol_reg;
            out_frow_reg  <= pend_frow_reg;
            out_tcol_reg  <= POS_W'(cur_col_reg);
            out_trow_reg  <= POS_W'(cur_row_reg);
            out_dir_reg   <= pend_dir_reg;
            out_walls_reg <= pend_walls_reg;
            out_depth_reg <= DEPTH_W'(sp_reg);
            out_done_reg  <= done_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_done_reg, out_depth_reg, out_walls_reg, out_dir_reg,
                       out_trow_reg, out_tcol_reg, out_frow_reg, out_fcol_reg};

    `MBS_ASSERT(a_sp_bound, sp_reg <= SPW'(CELLS), "stack pointer beyond capacity")
    `MBS_ASSERT(a_cnt_bound, vis_cnt_reg <= SPW'(CELLS), "visited count beyond cell count")
    `MBS_ASSERT(a_cur_in_grid, (cur_col_reg <= CW'(GRID_COLS - 1)) && (cur_row_reg <= RW'(GRID_ROWS - 1)), "current cell outside grid")
    `MBS_ASSERT_NEXT(a_emit_loads, out_load, m_valid_reg && (state_reg == ST_IDLE), "result not presented after emit")

endmodule

`default_nettype wire

[verif/tb_maze_backtracker_step_core.sv]
`timescale 1ns / 1ps

module tb_maze_backtracker_step_core;
    import maze_bt_pkg::*;

    localparam int GRID_COLS = 16;
    localparam int GRID_ROWS = 16;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int QUIET_LIMIT = 5000;
    localparam opcode_t OP_READ_ALT = 2'd3;

    typedef struct packed {
        opcode_t     op;
        logic [15:0] rnd;
        logic [3:0]  col;
        logic [3:0]  row;
    } maze_cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] from_col;
        logic [3:0] from_row;
        logic [3:0] to_col;
        logic [3:0] to_row;
        dir_t       dir;
        wall_t      walls;
        logic [8:0] depth;
        logic       done;
    } maze_event_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    opcode_t              s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    kind_t                m_tuser;

    maze_backtracker_step_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // predicted block state
    logic [4:0]  cols_reg = 5'd15;
    logic [4:0]  rows_reg = 5'd15;
    bit          visited [CELLS];
    logic [3:0]  wall_mem [CELLS];
    logic [7:0]  stack_mem [CELLS];
    int          stack_ptr;
    int          cur_col;
    int          cur_row;
    int          visited_total;

    maze_cmd_t   cmd_queue [$];
    maze_event_t pending_events [$];
    maze_cmd_t   next_cmd;
    maze_event_t want;
    logic        s_taken = 1'b0;
    int          reg_writes = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic int eff_dim(input logic [4:0] r);
        if (r == 0) return 1;
        if (r > GRID_COLS) return GRID_COLS;
        return int'(r);
    endfunction

    function automatic bit maze_complete();
        return visited_total >= eff_dim(cols_reg) * eff_dim(rows_reg);
    endfunction

    function automatic void maze_clear();
        for (int i = 0; i < CELLS; i++) begin
            visited[i] = 1'b0;
            wall_mem[i] = WALLS_ALL;
            stack_mem[i] = '0;
        end
        stack_ptr = 0;
        cur_col = 0;
        cur_row = 0;
        visited_total = 0;
    endfunction

    function automatic maze_event_t maze_advance(input opcode_t op, input logic [15:0] rnd,
                                                 input logic [3:0] rc, input logic [3:0] rr);
        maze_event_t ev;
        int cols, rows, cc, cr, here, there, n, k, idx;
        int nc [4];
        int nr [4];
        dir_t nd [4];
        wall_t own, far;
        ev = '0;
        ev.from_col = 4'(cur_col);
        ev.from_row = 4'(cur_row);
        if (op == OP_RESTART) begin
            maze_clear();
            ev.kind = EV_RESTARTED;
        end else if (op == OP_STEP) begin
            if (maze_complete()) begin
                ev.kind = EV_COMPLETE;
            end else begin
                cols = eff_dim(cols_reg);
                rows = eff_dim(rows_reg);
                cc = cur_col;
                cr = cur_row;
                here = cr * GRID_COLS + cc;
                n = 0;
                if (!visited[here]) begin
                    visited[here] = 1'b1;
                    visited_total++;
                end
                if (cc >= 1 && cc - 1 < cols && cr < rows && !visited[here - 1]) begin
                    nc[n] = cc - 1; nr[n] = cr; nd[n] = DIR_LEFT; n++;
                end
                if (cc + 1 < cols && cr < rows && !visited[here + 1]) begin
                    nc[n] = cc + 1; nr[n] = cr; nd[n] = DIR_RIGHT; n++;
                end
                if (cr >= 1 && cr - 1 < rows && cc < cols && !visited[here - GRID_COLS]) begin
                    nc[n] = cc; nr[n] = cr - 1; nd[n] = DIR_UP; n++;
                end
                if (cr + 1 < rows && cc < cols && !visited[here + GRID_COLS]) begin
                    nc[n] = cc; nr[n] = cr + 1; nd[n] = DIR_DOWN; n++;
                end
                if (n > 0) begin
                    k = int'(rnd) % n;
                    there = nr[k] * GRID_COLS + nc[k];
                    ev.dir = nd[k];
                    // walls: bit0 up, bit1 down, bit2 right, bit3 left
                    case (nd[k])
                        DIR_LEFT:  begin own = 4'b1000; far = 4'b0100; end
                        DIR_RIGHT: begin own = 4'b0100; far = 4'b1000; end
                        DIR_UP:    begin own = 4'b0001; far = 4'b0010; end
                        default:   begin own = 4'b0010; far = 4'b0001; end
                    endcase
                    wall_mem[here] = wall_mem[here] & ~own;
                    wall_mem[there] = wall_mem[there] & ~far;
                    if (stack_ptr < CELLS) begin
                        stack_mem[stack_ptr] = 8'(here);
                        stack_ptr++;
                    end
                    cur_col = nc[k];
                    cur_row = nr[k];
                    ev.kind = EV_CARVED;
                end else begin
                    if (stack_ptr > 0) begin
                        stack_ptr--;
                        idx = int'(stack_mem[stack_ptr]);
                        cur_col = idx % GRID_COLS;
                        cur_row = idx / GRID_COLS;
                    end
                    ev.kind = EV_BACKTRACK;
                end
            end
        end else begin
            ev.walls = wall_mem[int'(rr) * GRID_COLS + int'(rc)];
            ev.kind = EV_READOUT;
        end
        ev.to_col = 4'(cur_col);
        ev.to_row = 4'(cur_row);
        ev.depth = 9'(stack_ptr);
        ev.done = maze_complete();
        return ev;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // input driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_taken) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_queue.pop_front();
                    s_tdata <= {next_cmd.row, next_cmd.col, next_cmd.rnd};
                    s_tuser <= next_cmd.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predictor, checker and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            maze_clear();
            cols_reg = 5'd15;
            rows_reg = 5'd15;
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_COLS) begin
                    cols_reg = cfg_data;
                end else begin
                    rows_reg = cfg_data;
                end
                reg_writes <= reg_writes + 1;
            end
            if (s_tvalid && s_tready) begin
                pending_events.push_back(maze_advance(s_tuser, s_tdata[15:0],
                                                      s_tdata[19:16], s_tdata[23:20]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.kind, m_tuser);
                    check_field("from_col", want.from_col, m_tdata[3:0]);
                    check_field("from_row", want.from_row, m_tdata[7:4]);
                    check_field("to_col", want.to_col, m_tdata[11:8]);
                    check_field("to_row", want.to_row, m_tdata[15:12]);
                    check_field("carved_dir", want.dir, m_tdata[17:16]);
                    check_field("wall_bits", want.walls, m_tdata[21:18]);
                    check_field("stack_depth", want.depth, m_tdata[30:22]);
                    check_field("maze_done", want.done, m_tdata[31]);
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic set_pace(input int mode);
        case (mode)
            0:       begin send_idle_pct = 37; recv_idle_pct = 74; end
            1:       begin send_idle_pct = 74; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [4:0] val);
        int seen;
        seen = reg_writes;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (reg_writes == seen) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(input opcode_t op, input logic [15:0] rnd,
                            input logic [3:0] col, input logic [3:0] row);
        cmd_queue.push_back('{op: op, rnd: rnd, col: col, row: row});
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || pending_events.size() != 0 || s_tvalid)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // mostly steps with random choices; reads, alternate reads and restarts mixed in
    task automatic push_random_cmd();
        int pick;
        opcode_t op;
        pick = $urandom_range(99);
        if (pick < 84) begin
            op = OP_STEP;
        end else if (pick < 93) begin
            op = OP_READ;
        end else if (pick < 97) begin
            op = OP_READ_ALT;
        end else begin
            op = OP_RESTART;
        end
        push_cmd(op, 16'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic run_phase(input logic [4:0] cols, input logic [4:0] rows, input int count,
                             input bit fresh, input int mode);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        set_pace(mode);
        if (fresh) begin
            push_cmd(OP_RESTART, 16'($urandom), 4'($urandom), 4'($urandom));
        end
        repeat (count - int'(fresh)) push_random_cmd();
        wait_idle();
    endtask

    initial begin
        set_pace(0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default 15x15 walk from reset
        push_cmd(OP_READ, 16'h0000, 4'd0, 4'd0);
        push_cmd(OP_READ_ALT, 16'hFFFF, 4'd15, 4'd15);
        push_cmd(OP_STEP, 16'h0000, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'hFFFF, 4'd15, 4'd15);
        push_cmd(OP_STEP, 16'h5555, 4'd5, 4'd10);
        push_cmd(OP_STEP, 16'hAAAA, 4'd10, 4'd5);
        push_cmd(OP_READ, 16'h0001, 4'd1, 4'd0);
        push_cmd(OP_READ, 16'h8000, 4'd0, 4'd1);
        wait_idle();

        // shrink the grid in the middle of a walk
        write_reg(REG_COLS, 5'd2);
        write_reg(REG_ROWS, 5'd2);
        push_cmd(OP_STEP, 16'h0003, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'h0002, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'h0001, 4'd0, 4'd0);
        push_cmd(OP_READ, 16'h0000, 4'd1, 4'd1);
        wait_idle();

        // zero registers act as a 1x1 grid: lone cell backtracks, then completion
        write_reg(REG_COLS, 5'd0);
        write_reg(REG_ROWS, 5'd0);
        push_cmd(OP_RESTART, 16'h0000, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'h1234, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'h4321, 4'd0, 4'd0);
        push_cmd(OP_STEP, 16'hFFFF, 4'd0, 4'd0);
        wait_idle();

        run_phase(5'd3, 5'd2, 60, 1'b1, 0);
        run_phase(5'd16, 5'd1, 60, 1'b1, 0);
        run_phase(5'd1, 5'd16, 60, 1'b1, 0);
        run_phase(5'd31, 5'd17, 80, 1'b1, 1);
        run_phase(5'd5, 5'd7, 120, 1'b1, 1);
        run_phase(5'd8, 5'd4, 100, 1'b0, 1);
        run_phase(5'd2, 5'd2, 40, 1'b1, 2);
        run_phase(5'd16, 5'd16, 330, 1'b1, 2);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/maze_bt_pkg.sv
rtl/core/maze_backtracker_step_core.sv
verif/tb_maze_backtracker_step_core.sv
